>>> hdl/tpst_pkg.sv
// Shared types and constants for the touch polar sample tagger.
// Holds the channel payload structs, the row kinds, the state encodings and
// the arctangent table of the iterative CORDIC. No dependencies.
package tpst_pkg;

  localparam int SCREEN_SPAN = 240;
  localparam logic [9:0] CENTRE = 10'(SCREEN_SPAN / 2);

  localparam logic [4:0] CORDIC_STEPS = 5'd20;
  localparam logic [3:0] ROOT_TOP_BIT = 4'd11;
  localparam logic [11:0] ANGLE_MAX = 12'd3600;
  localparam logic [11:0] ANGLE_UP = 12'd0;
  localparam logic [11:0] ANGLE_RIGHT = 12'd900;
  localparam logic [11:0] ANGLE_DOWN = 12'd1800;
  localparam logic [11:0] ANGLE_LEFT = 12'd2700;

  // Angle accumulator units: 1/65536 of a tenth of a degree.
  localparam logic signed [29:0] ANG_HALF = 30'sd117964800;
  localparam logic signed [29:0] ANG_FULL = 30'sd235929600;
  localparam logic signed [29:0] ANG_ROUND = 30'sd32768;

  localparam logic [1:0] CFG_BAND_INNER = 2'd0;
  localparam logic [1:0] CFG_BAND_OUTER = 2'd1;
  localparam logic [1:0] CFG_IDLE_INTERVAL = 2'd2;

  localparam logic [21:0] BAND_INNER_RESET = 22'd7465;
  localparam logic [21:0] BAND_OUTER_RESET = 22'd14981;
  localparam logic [31:0] IDLE_INTERVAL_RESET = 32'd100000;

  typedef enum logic [1:0] {
    ROW_SAMPLE = 2'd0,
    ROW_IDLE   = 2'd1,
    ROW_MARK   = 2'd2
  } row_kind_t;

  typedef struct packed {
    logic        touched;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [31:0] now_us;
  } tpst_in_t;

  typedef struct packed {
    row_kind_t   row_kind;
    logic [31:0] seq_number;
    logic [31:0] stamp_us;
    logic [31:0] delta_us;
    logic [9:0]  out_x;
    logic [9:0]  out_y;
    logic [10:0] radius_px;
    logic [11:0] angle_tenths;
    logic        in_band;
    logic [31:0] stroke_total;
    logic        last_of_run;
  } tpst_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_ROW
  } tag_state_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SQX,
    PH_SQY,
    PH_ROOT,
    PH_ROUND,
    PH_VEC,
    PH_ANG,
    PH_FIN
  } unit_phase_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Rounded arctangent of 2^-idx in angle accumulator units.
  function automatic logic [24:0] atan_entry(input logic [4:0] idx);
    logic [24:0] v;
    begin
      case (idx)
        5'd0:  v = 25'd29491200;
        5'd1:  v = 25'd17409672;
        5'd2:  v = 25'd9198793;
        5'd3:  v = 25'd4669451;
        5'd4:  v = 25'd2343786;
        5'd5:  v = 25'd1173036;
        5'd6:  v = 25'd586661;
        5'd7:  v = 25'd293348;
        5'd8:  v = 25'd146676;
        5'd9:  v = 25'd73339;
        5'd10: v = 25'd36669;
        5'd11: v = 25'd18335;
        5'd12: v = 25'd9167;
        5'd13: v = 25'd4584;
        5'd14: v = 25'd2292;
        5'd15: v = 25'd1146;
        5'd16: v = 25'd573;
        5'd17: v = 25'd286;
        5'd18: v = 25'd143;
        5'd19: v = 25'd72;
        default: v = 25'd0;
      endcase
      return v;
    end
  endfunction

endpackage

>>> hdl/tpst_polar_unit.sv
// Iterative polar conversion: squared radius, rounded square root and
// CORDIC vectoring angle, all on one shared multiplier and shift-add datapath.
// Depends on tpst_pkg.
module tpst_polar_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [9:0]            pos_x,
  input  logic [9:0]            pos_y,
  output tpst_pkg::unit_stat_t  stat,
  output logic [10:0]           radius_px,
  output logic [11:0]           angle_tenths,
  output logic [21:0]           radius_sq
);

  tpst_pkg::unit_phase_t phase_r, phase_nxt;
  logic                  done_r, done_nxt;
  logic signed [11:0]    dx_r, dx_nxt;
  logic signed [11:0]    dy_r, dy_nxt;
  logic [21:0]           sqx_r, sqx_nxt;
  logic [21:0]           s_r, s_nxt;
  logic [11:0]           n_r, n_nxt;
  logic [21:0]           nsq_r, nsq_nxt;
  logic [3:0]            k_r, k_nxt;
  logic signed [33:0]    x_r, x_nxt;
  logic signed [33:0]    y_r, y_nxt;
  logic signed [29:0]    z_r, z_nxt;
  logic                  neg_r, neg_nxt;
  logic [4:0]            i_r, i_nxt;
  logic [11:0]           ang_r, ang_nxt;

  logic signed [12:0]    mul_a;
  logic signed [12:0]    mul_b;
  logic signed [25:0]    prod;
  logic [11:0]           trial;
  logic signed [33:0]    xs;
  logic signed [33:0]    ys;
  logic signed [29:0]    atan_v;
  logic signed [11:0]    nn;
  logic signed [29:0]    zb;
  logic signed [29:0]    rnd;
  logic [12:0]           quo;

  assign trial  = n_r | (12'd1 << k_r);
  assign xs     = x_r >>> i_r;
  assign ys     = y_r >>> i_r;
  assign atan_v = $signed({5'b0, tpst_pkg::atan_entry(i_r)});
  assign nn     = -dy_r;
  assign prod   = mul_a * mul_b;

  always_comb begin
    mul_a = 13'sd0;
    mul_b = 13'sd0;
    case (phase_r)
      tpst_pkg::PH_SQX: begin
        mul_a = {dx_r[11], dx_r};
        mul_b = {dx_r[11], dx_r};
      end
      tpst_pkg::PH_SQY: begin
        mul_a = {dy_r[11], dy_r};
        mul_b = {dy_r[11], dy_r};
      end
      tpst_pkg::PH_ROOT: begin
        mul_a = $signed({1'b0, trial});
        mul_b = $signed({1'b0, trial});
      end
      default: begin
        mul_a = 13'sd0;
        mul_b = 13'sd0;
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    done_nxt  = done_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    sqx_nxt   = sqx_r;
    s_nxt     = s_r;
    n_nxt     = n_r;
    nsq_nxt   = nsq_r;
    k_nxt     = k_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    neg_nxt   = neg_r;
    i_nxt     = i_r;
    ang_nxt   = ang_r;
    zb        = z_r + (neg_r ? tpst_pkg::ANG_HALF : 30'sd0);
    rnd       = z_r + tpst_pkg::ANG_ROUND;
    quo       = rnd[28:16];
    if (start) begin
      dx_nxt    = $signed({2'b0, pos_x}) - $signed({2'b0, tpst_pkg::CENTRE});
      dy_nxt    = $signed({2'b0, pos_y}) - $signed({2'b0, tpst_pkg::CENTRE});
      done_nxt  = 1'b0;
      phase_nxt = tpst_pkg::PH_SQX;
    end else begin
      unique case (phase_r)
        tpst_pkg::PH_IDLE: begin
          phase_nxt = tpst_pkg::PH_IDLE;
        end
        tpst_pkg::PH_SQX: begin
          sqx_nxt   = prod[21:0];
          phase_nxt = tpst_pkg::PH_SQY;
        end
        tpst_pkg::PH_SQY: begin
          s_nxt     = sqx_r + prod[21:0];
          n_nxt     = 12'd0;
          nsq_nxt   = 22'd0;
          k_nxt     = tpst_pkg::ROOT_TOP_BIT;
          phase_nxt = tpst_pkg::PH_ROOT;
        end
        tpst_pkg::PH_ROOT: begin
          // Keep the trial bit when its square still fits under s.
          if (prod[23:0] <= {2'b0, s_r}) begin
            n_nxt   = trial;
            nsq_nxt = prod[21:0];
          end
          k_nxt = k_r - 4'd1;
          if (k_r == 4'd0) begin
            phase_nxt = tpst_pkg::PH_ROUND;
          end
        end
        tpst_pkg::PH_ROUND: begin
          if ((s_r - nsq_r) > {10'b0, n_r}) begin
            n_nxt = n_r + 12'd1;
          end
          z_nxt = 30'sd0;
          i_nxt = 5'd0;
          if (dx_r == 12'sd0) begin
            ang_nxt   = (dy_r < 12'sd0) ? tpst_pkg::ANGLE_UP : tpst_pkg::ANGLE_DOWN;
            done_nxt  = 1'b1;
            phase_nxt = tpst_pkg::PH_IDLE;
          end else if (dy_r == 12'sd0) begin
            ang_nxt   = (dx_r > 12'sd0) ? tpst_pkg::ANGLE_RIGHT : tpst_pkg::ANGLE_LEFT;
            done_nxt  = 1'b1;
            phase_nxt = tpst_pkg::PH_IDLE;
          end else begin
            // Start in the right half plane; the left half adds 180 degrees.
            if (nn < 12'sd0) begin
              x_nxt   = {{2{dy_r[11]}}, dy_r, 20'b0};
              y_nxt   = -{{2{dx_r[11]}}, dx_r, 20'b0};
              neg_nxt = 1'b1;
            end else begin
              x_nxt   = {{2{nn[11]}}, nn, 20'b0};
              y_nxt   = {{2{dx_r[11]}}, dx_r, 20'b0};
              neg_nxt = 1'b0;
            end
            phase_nxt = tpst_pkg::PH_VEC;
          end
        end
        tpst_pkg::PH_VEC: begin
          if (y_r > 34'sd0) begin
            x_nxt = x_r + ys;
            y_nxt = y_r - xs;
            z_nxt = z_r + atan_v;
          end else begin
            x_nxt = x_r - ys;
            y_nxt = y_r + xs;
            z_nxt = z_r - atan_v;
          end
          i_nxt = i_r + 5'd1;
          if (i_r == tpst_pkg::CORDIC_STEPS - 5'd1) begin
            phase_nxt = tpst_pkg::PH_ANG;
          end
        end
        tpst_pkg::PH_ANG: begin
          z_nxt     = (zb < 30'sd0) ? zb + tpst_pkg::ANG_FULL : zb;
          phase_nxt = tpst_pkg::PH_FIN;
        end
        tpst_pkg::PH_FIN: begin
          ang_nxt   = (quo > {1'b0, tpst_pkg::ANGLE_MAX}) ? tpst_pkg::ANGLE_MAX : quo[11:0];
          done_nxt  = 1'b1;
          phase_nxt = tpst_pkg::PH_IDLE;
        end
        default: begin
          phase_nxt = tpst_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tpst_pkg::PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    sqx_r <= sqx_nxt;
    s_r   <= s_nxt;
    n_r   <= n_nxt;
    nsq_r <= nsq_nxt;
    k_r   <= k_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    neg_r <= neg_nxt;
    i_r   <= i_nxt;
    ang_r <= ang_nxt;
  end

  assign stat.busy    = (phase_r != tpst_pkg::PH_IDLE);
  assign stat.done    = done_r;
  assign radius_px    = n_r[10:0];
  assign angle_tenths = ang_r;
  assign radius_sq    = s_r;

endmodule

>>> hdl/touch_polar_sample_tagger.sv
// Touch polar sample tagger: turns touch-panel polls into sample, idle and
// stroke-ended rows. Depends on tpst_pkg and tpst_polar_unit.
// A touched poll's sample row waits for the polar unit's 12 root steps and
// 20 CORDIC steps; the centre and points on an axis skip the CORDIC.
// Marker and idle rows go to the output register as soon as it is free.
// A new poll is taken only once every row of the previous poll has been
// handed to the output register; an untouched poll with no row does not
// hold off the next one.
// Reset (synchronous, active low) restores the register defaults and clears
// all counters and flags at once; no clearing pass follows.
module touch_polar_sample_tagger (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpst_pkg::tpst_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tpst_pkg::tpst_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  // Configuration registers. The port is always ready; an index past the
  // register list is taken and dropped.
  logic [21:0] band_inner_r;
  logic [21:0] band_outer_r;
  logic [31:0] idle_iv_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_inner_r <= tpst_pkg::BAND_INNER_RESET;
      band_outer_r <= tpst_pkg::BAND_OUTER_RESET;
      idle_iv_r    <= tpst_pkg::IDLE_INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpst_pkg::CFG_BAND_INNER:    band_inner_r <= cfg_data[21:0];
        tpst_pkg::CFG_BAND_OUTER:    band_outer_r <= cfg_data[21:0];
        tpst_pkg::CFG_IDLE_INTERVAL: idle_iv_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Poll history. All of it is updated at the moment a poll transfers, so
  // the rows of that poll are fully decided there; only the polar figures of
  // a sample row arrive later from the polar unit.
  tpst_pkg::tag_state_t state_r, state_nxt;
  logic [31:0] row_ctr_r, row_ctr_nxt;
  logic [31:0] prev_time_r, prev_time_nxt;
  logic        was_down_r, was_down_nxt;
  logic [31:0] strokes_r, strokes_nxt;
  logic [31:0] last_idle_r, last_idle_nxt;

  // The poll being answered.
  logic [31:0]         now_r, now_nxt;
  logic [31:0]         dt_r, dt_nxt;
  logic [9:0]          px_r, px_nxt;
  logic [9:0]          py_r, py_nxt;
  logic [31:0]         seq_r, seq_nxt;
  logic                has_row_r, has_row_nxt;
  tpst_pkg::row_kind_t kind_r, kind_nxt;

  // Output register, which lets the next poll in while a row waits.
  logic                out_valid_r, out_valid_nxt;
  tpst_pkg::tpst_out_t out_data_r, out_data_nxt;

  logic                 in_accept;
  logic                 slot_free;
  logic [31:0]          poll_dt;
  logic                 release_now;
  logic                 idle_due;
  logic                 unit_start;
  tpst_pkg::unit_stat_t unit_stat;
  logic [10:0]          unit_radius;
  logic [11:0]          unit_angle;
  logic [21:0]          unit_sq;
  logic                 band_hit;

  assign in_stall    = (state_r != tpst_pkg::ST_IDLE);
  assign in_accept   = in_valid && !in_stall;
  assign slot_free   = !out_valid_r || !out_stall;
  assign poll_dt     = in_data.now_us - prev_time_r;
  assign release_now = was_down_r && !in_data.touched;
  assign idle_due    = !in_data.touched && ((in_data.now_us - last_idle_r) > idle_iv_r);
  assign unit_start  = in_accept && in_data.touched;
  assign band_hit    = (unit_sq >= band_inner_r) && (unit_sq <= band_outer_r);

  tpst_polar_unit u_polar (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (unit_start),
    .pos_x        (in_data.pos_x),
    .pos_y        (in_data.pos_y),
    .stat         (unit_stat),
    .radius_px    (unit_radius),
    .angle_tenths (unit_angle),
    .radius_sq    (unit_sq)
  );

  // Sequencer: on a transfer it books the poll's rows, then hands them to
  // the output register one at a time: the stroke-ended marker first, then
  // the sample or idle row. A sample row waits for the polar unit.
  always_comb begin
    state_nxt     = state_r;
    row_ctr_nxt   = row_ctr_r;
    prev_time_nxt = prev_time_r;
    was_down_nxt  = was_down_r;
    strokes_nxt   = strokes_r;
    last_idle_nxt = last_idle_r;
    now_nxt       = now_r;
    dt_nxt        = dt_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    seq_nxt       = seq_r;
    has_row_nxt   = has_row_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      tpst_pkg::ST_IDLE: begin
        if (in_accept) begin
          now_nxt       = in_data.now_us;
          dt_nxt        = poll_dt;
          px_nxt        = in_data.pos_x;
          py_nxt        = in_data.pos_y;
          seq_nxt       = row_ctr_r;
          prev_time_nxt = in_data.now_us;
          was_down_nxt  = in_data.touched;
          has_row_nxt   = in_data.touched || idle_due;
          kind_nxt      = in_data.touched ? tpst_pkg::ROW_SAMPLE : tpst_pkg::ROW_IDLE;
          if (release_now) begin
            strokes_nxt = strokes_r + 32'd1;
          end
          if (in_data.touched || idle_due) begin
            row_ctr_nxt = row_ctr_r + 32'd1;
          end
          if (idle_due) begin
            last_idle_nxt = in_data.now_us;
          end
          if (release_now) begin
            state_nxt = tpst_pkg::ST_MARK;
          end else if (in_data.touched || idle_due) begin
            state_nxt = tpst_pkg::ST_ROW;
          end
        end
      end
      tpst_pkg::ST_MARK: begin
        if (slot_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt              = '0;
          out_data_nxt.row_kind     = tpst_pkg::ROW_MARK;
          out_data_nxt.stamp_us     = now_r;
          out_data_nxt.delta_us     = dt_r;
          out_data_nxt.stroke_total = strokes_r;
          out_data_nxt.last_of_run  = !has_row_r;
          state_nxt = has_row_r ? tpst_pkg::ST_ROW : tpst_pkg::ST_IDLE;
        end
      end
      tpst_pkg::ST_ROW: begin
        if (slot_free && (kind_r == tpst_pkg::ROW_IDLE || unit_stat.done)) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt             = '0;
          out_data_nxt.row_kind    = kind_r;
          out_data_nxt.seq_number  = seq_r;
          out_data_nxt.stamp_us    = now_r;
          out_data_nxt.delta_us    = dt_r;
          out_data_nxt.last_of_run = 1'b1;
          if (kind_r == tpst_pkg::ROW_SAMPLE) begin
            out_data_nxt.out_x        = px_r;
            out_data_nxt.out_y        = py_r;
            out_data_nxt.radius_px    = unit_radius;
            out_data_nxt.angle_tenths = unit_angle;
            out_data_nxt.in_band      = band_hit;
          end
          state_nxt = tpst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tpst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpst_pkg::ST_IDLE;
      row_ctr_r   <= 32'd0;
      prev_time_r <= 32'd0;
      was_down_r  <= 1'b0;
      strokes_r   <= 32'd0;
      last_idle_r <= 32'd0;
      has_row_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_ctr_r   <= row_ctr_nxt;
      prev_time_r <= prev_time_nxt;
      was_down_r  <= was_down_nxt;
      strokes_r   <= strokes_nxt;
      last_idle_r <= last_idle_nxt;
      has_row_r   <= has_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    dt_r       <= dt_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    seq_r      <= seq_nxt;
    kind_r     <= kind_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // The polar unit has finished by the time the sequencer is free again.
  a_unit_quiet_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tpst_pkg::ST_IDLE) |-> !unit_stat.busy)
    else $error("polar unit still busy while the sequencer is idle");

  // A marker that is not the last row of its poll always has a row behind it.
  a_marker_has_follower: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.row_kind == tpst_pkg::ROW_MARK && !out_data_r.last_of_run)
      |-> (state_r == tpst_pkg::ST_ROW))
    else $error("stroke-ended marker not followed by a row");

  // Sample rows carry an angle inside a full turn.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.row_kind == tpst_pkg::ROW_SAMPLE)
      |-> (out_data_r.angle_tenths <= tpst_pkg::ANGLE_MAX))
    else $error("sample row angle beyond a full turn");
`endif

endmodule

>>> bench/tpst_row_checker.sv
`timescale 1ns / 100ps
// Row checker for the touch polar sample tagger bench: watches the poll, row
// and register channels, predicts every row and compares. Depends on tpst_pkg.
module tpst_row_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  tpst_pkg::tpst_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  tpst_pkg::tpst_out_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  fail_count,
  output int                  rows_waiting
);
  import tpst_pkg::*;

  localparam longint ANGLE_UNIT = 65536;
  localparam longint TIE_WINDOW = 1024;
  localparam int PRINT_CAP = 200;

  typedef struct {
    tpst_out_t row;
    bit        angle_tie;
  } due_row_t;

  longint arctan_step [20] = '{
    29491200, 17409672, 9198793, 4669451, 2343786, 1173036, 586661, 293348,
    146676, 73339, 36669, 18335, 9167, 4584, 2292, 1146, 573, 286, 143, 72
  };

  logic [21:0] band_inner;
  logic [21:0] band_outer;
  logic [31:0] idle_gap_us;
  logic [31:0] row_count;
  logic [31:0] last_poll_us;
  logic [31:0] last_idle_us;
  logic [31:0] stroke_count;
  bit          finger_down;
  int          rows_checked;
  due_row_t    rows_due [$];

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) $display("row %0d: %s", rows_checked, what);
    fail_count++;
  endtask

  // Rounded radius, squared radius and clockwise angle from 12 o'clock. The
  // angle is a 20-step vectoring CORDIC on (north, east) in 2^20 scaling.
  task automatic polar_of(input logic [9:0] px, input logic [9:0] py,
                          output logic [31:0] sq, output logic [10:0] radius,
                          output logic [11:0] angle, output bit near_tie);
    int dx;
    int dy;
    logic [31:0] n;
    logic [31:0] t;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint base;
    dx = int'(px) - int'(CENTRE);
    dy = int'(py) - int'(CENTRE);
    sq = 32'(dx * dx) + 32'(dy * dy);
    n = '0;
    for (int b = 11; b >= 0; b--) begin
      t = n | (32'd1 << b);
      if (t * t <= sq) n = t;
    end
    if (sq - n * n > n) n = n + 1;
    radius = n[10:0];
    near_tie = 1'b0;
    if (dx == 0) begin
      angle = (dy < 0) ? ANGLE_UP : ANGLE_DOWN;
    end else if (dy == 0) begin
      angle = (dx > 0) ? ANGLE_RIGHT : ANGLE_LEFT;
    end else begin
      x = longint'(-dy) <<< 20;
      y = longint'(dx) <<< 20;
      base = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        base = ANG_HALF;
      end
      z = 0;
      for (int i = 0; i < 20; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + arctan_step[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - arctan_step[i];
        end
      end
      z = z + base;
      if (z < 0) z = z + ANG_FULL;
      near_tie = ((z % ANGLE_UNIT) >= ANGLE_UNIT / 2 - TIE_WINDOW) &&
                 ((z % ANGLE_UNIT) <= ANGLE_UNIT / 2 + TIE_WINDOW);
      z = (z + ANGLE_UNIT / 2) / ANGLE_UNIT;
      if (z > 3600) z = 3600;
      angle = z[11:0];
    end
  endtask

  function automatic due_row_t blank_row(input row_kind_t kind, input logic [31:0] stamp,
                                         input logic [31:0] delta);
    due_row_t r;
    r.row = '0;
    r.row.row_kind = kind;
    r.row.stamp_us = stamp;
    r.row.delta_us = delta;
    r.angle_tie = 1'b0;
    return r;
  endfunction

  task automatic tag_poll(input tpst_in_t poll);
    due_row_t made [2];
    int count;
    logic [31:0] dt;
    logic [31:0] sq;
    logic [10:0] radius;
    logic [11:0] angle;
    bit tie;
    count = 0;
    dt = poll.now_us - last_poll_us;
    last_poll_us = poll.now_us;
    if (finger_down && !poll.touched) begin
      stroke_count = stroke_count + 1;
      made[count] = blank_row(ROW_MARK, poll.now_us, dt);
      made[count].row.stroke_total = stroke_count;
      count++;
    end
    finger_down = poll.touched;
    if (poll.touched) begin
      polar_of(poll.pos_x, poll.pos_y, sq, radius, angle, tie);
      made[count] = blank_row(ROW_SAMPLE, poll.now_us, dt);
      made[count].row.seq_number = row_count;
      made[count].row.out_x = poll.pos_x;
      made[count].row.out_y = poll.pos_y;
      made[count].row.radius_px = radius;
      made[count].row.angle_tenths = angle;
      made[count].row.in_band = (sq >= band_inner) && (sq <= band_outer);
      made[count].angle_tie = tie;
      row_count = row_count + 1;
      count++;
    end else if (poll.now_us - last_idle_us > idle_gap_us) begin
      last_idle_us = poll.now_us;
      made[count] = blank_row(ROW_IDLE, poll.now_us, dt);
      made[count].row.seq_number = row_count;
      row_count = row_count + 1;
      count++;
    end
    if (count > 0) made[count - 1].row.last_of_run = 1'b1;
    for (int k = 0; k < count; k++) rows_due.push_back(made[k]);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic compare_row(input tpst_out_t got);
    due_row_t want;
    int skew;
    if (rows_due.size() == 0) begin
      report_mismatch($sformatf("row kind %0d seq %0d arrived with nothing due",
                                got.row_kind, got.seq_number));
    end else begin
      want = rows_due.pop_front();
      check_field("row_kind", 32'(got.row_kind), 32'(want.row.row_kind));
      check_field("seq_number", got.seq_number, want.row.seq_number);
      check_field("stamp_us", got.stamp_us, want.row.stamp_us);
      check_field("delta_us", got.delta_us, want.row.delta_us);
      check_field("out_x", 32'(got.out_x), 32'(want.row.out_x));
      check_field("out_y", 32'(got.out_y), 32'(want.row.out_y));
      check_field("radius_px", 32'(got.radius_px), 32'(want.row.radius_px));
      // A CORDIC result sitting on a rounding tie may land one tenth away.
      skew = int'(got.angle_tenths) - int'(want.row.angle_tenths);
      if (!(want.angle_tie && (skew == 1 || skew == -1)))
        check_field("angle_tenths", 32'(got.angle_tenths), 32'(want.row.angle_tenths));
      check_field("in_band", 32'(got.in_band), 32'(want.row.in_band));
      check_field("stroke_total", got.stroke_total, want.row.stroke_total);
      check_field("last_of_run", 32'(got.last_of_run), 32'(want.row.last_of_run));
    end
    rows_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      band_inner = BAND_INNER_RESET;
      band_outer = BAND_OUTER_RESET;
      idle_gap_us = IDLE_INTERVAL_RESET;
      row_count = '0;
      last_poll_us = '0;
      last_idle_us = '0;
      stroke_count = '0;
      finger_down = 1'b0;
      rows_checked = 0;
      fail_count = 0;
      rows_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BAND_INNER:    band_inner = cfg_data[21:0];
          CFG_BAND_OUTER:    band_outer = cfg_data[21:0];
          CFG_IDLE_INTERVAL: idle_gap_us = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) tag_poll(in_data);
      if (out_valid && !out_stall) compare_row(out_data);
    end
    rows_waiting <= rows_due.size();
  end

endmodule

>>> bench/touch_polar_sample_tagger_tb.sv
`timescale 1ns / 100ps
// Top of the touch polar sample tagger bench: clock, reset, poll and register
// stimulus, result-side stalls and the verdict. Depends on tpst_pkg, the
// tagger RTL and tpst_row_checker.
module touch_polar_sample_tagger_tb;
  import tpst_pkg::*;

  // The slowest correct run is roughly 550 polls, each costing a sender gap,
  // the polar work and up to two rows under long stalls, plus the settling
  // pauses. The limit is several times that.
  localparam int RUN_LIMIT = 400000;
  // Quiet cycles waited after the last due row, so that the block has gone idle.
  localparam int SETTLE_CYCLES = 48;
  // The register port has a fourth index that selects nothing.
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int SPAN_TOP = SCREEN_SPAN - 1;
  localparam int PANEL_TOP = 1023;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_SPARSE,
    STALL_HOLD
  } stall_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  tpst_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  tpst_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_BAND_INNER;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          rows_waiting;
  int          cycle_count = 0;

  // Sender bookkeeping: the panel clock, the finger position and the burst.
  logic [31:0] clock_us = '0;
  int          burst_left = 0;
  int          polls_sent = 0;
  int          last_x = 120;
  int          last_y = 120;

  // Receiver stall pattern.
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          hold_left = 0;

  always #5 clk = ~clk;

  touch_polar_sample_tagger u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tpst_row_checker u_row_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .rows_waiting (rows_waiting)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("touch_polar_sample_tagger: mismatch");
      $finish;
    end
  end

  // The result side switches between stretches of no stalls, coin-flip
  // stalls, rare stalls and long held stalls, so that back pressure hits
  // marker, idle and sample rows in every phase of the block's work.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 160);
    end else begin
      mode_left = mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_COIN:   out_stall <= 1'($urandom_range(0, 1));
      STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (hold_left > 0) begin
          out_stall <= 1'b1;
          hold_left = hold_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
          out_stall <= 1'b1;
          hold_left = $urandom_range(1, 12);
        end else begin
          out_stall <= 1'b0;
        end
      end
    endcase
  end

  function automatic int pin(input int v, input int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  // Offers one poll and returns at the edge where it transfers. Polls go out
  // in bursts; between bursts valid drops for a random gap. A zero gap keeps
  // valid high so that some bursts run straight into each other.
  task automatic send_poll(input logic touched, input int px, input int py,
                           input logic [31:0] stamp);
    tpst_in_t poll;
    int gap;
    poll.touched = touched;
    poll.pos_x = px[9:0];
    poll.pos_y = py[9:0];
    poll.now_us = stamp;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_data <= poll;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left = burst_left - 1;
    polls_sent++;
  endtask

  // Stops offering polls, waits for every due row to come out, then lets the
  // block finish any poll that produces no row before registers change.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (rows_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers back to back with valid held high; the spare
  // index, which the block must ignore, is optionally slipped in.
  task automatic load_config(input logic [31:0] inner, input logic [31:0] outer,
                             input logic [31:0] interval, input bit poke_spare);
    logic [1:0]  idx [4];
    logic [31:0] val [4];
    idx = '{CFG_BAND_INNER, CFG_BAND_OUTER, CFG_SPARE, CFG_IDLE_INTERVAL};
    val = '{inner, outer, $urandom, interval};
    for (int k = 0; k < 4; k++) begin
      if (idx[k] == CFG_SPARE && !poke_spare) continue;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // The finger mostly drifts a little; now and then it jumps somewhere new.
  task automatic wander(input int hi);
    if ($urandom_range(0, 4) == 0) begin
      last_x = $urandom_range(0, hi);
      last_y = $urandom_range(0, hi);
    end else begin
      last_x = pin(last_x + int'($urandom_range(0, 40)) - 20, hi);
      last_y = pin(last_y + int'($urandom_range(0, 40)) - 20, hi);
    end
  endtask

  // A well-formed stroke: a few touched polls, then the release poll, which
  // carries junk coordinates that the block must not echo.
  task automatic stroke(input int hi);
    int touches;
    touches = $urandom_range(1, 8);
    for (int k = 0; k < touches; k++) begin
      wander(hi);
      clock_us = clock_us + $urandom_range(500, 20000);
      send_poll(1'b1, last_x, last_y, clock_us);
    end
    clock_us = clock_us + $urandom_range(500, 250000);
    send_poll(1'b0, $urandom_range(0, PANEL_TOP), $urandom_range(0, PANEL_TOP), clock_us);
  endtask

  // Untouched polls, half of them far enough apart to cross the idle interval.
  task automatic untouched_run(input int polls);
    for (int k = 0; k < polls; k++) begin
      if ($urandom_range(0, 1) == 0) clock_us = clock_us + $urandom_range(1000, 60000);
      else clock_us = clock_us + $urandom_range(60000, 400000);
      send_poll(1'b0, $urandom_range(0, PANEL_TOP), $urandom_range(0, PANEL_TOP), clock_us);
    end
  endtask

  // Mostly strokes on the visible screen, some across the whole raw panel
  // range, some idle stretches, and a little noise with arbitrary timestamps
  // that also drives the panel clock through its wrap.
  task automatic run_polls(input int target);
    int first;
    int pick;
    first = polls_sent;
    while (polls_sent - first < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        stroke(SPAN_TOP);
      end else if (pick == 6) begin
        stroke(PANEL_TOP);
      end else if (pick < 9) begin
        untouched_run($urandom_range(1, 4));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          clock_us = $urandom;
          send_poll(1'($urandom_range(0, 1)), $urandom_range(0, PANEL_TOP),
                    $urandom_range(0, PANEL_TOP), clock_us);
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed polls under the reset register values. An untouched poll at
    // time zero produces nothing, since no idle interval has passed.
    send_poll(1'b0, 0, 0, 32'd0);
    // Centre point, then the four axis directions.
    send_poll(1'b1, int'(CENTRE), int'(CENTRE), 32'd10);
    send_poll(1'b1, 120, 0, 32'd20);
    send_poll(1'b1, 240, 120, 32'd30);
    send_poll(1'b1, 120, 240, 32'd40);
    send_poll(1'b1, 0, 120, 32'd50);
    // Raw panel corners, far off the visible screen.
    send_poll(1'b1, 0, 0, 32'd60);
    send_poll(1'b1, PANEL_TOP, PANEL_TOP, 32'd70);
    send_poll(1'b1, PANEL_TOP, 0, 32'd80);
    send_poll(1'b1, 0, PANEL_TOP, 32'd90);
    // Inside the default bezel band, and one diagonal step off the centre.
    send_poll(1'b1, 220, 120, 32'd100);
    send_poll(1'b1, 121, 119, 32'd110);
    // A long release: the marker and an idle row from the same poll.
    send_poll(1'b0, PANEL_TOP, PANEL_TOP, 32'd300000);
    send_poll(1'b0, 0, 0, 32'd350000);
    // A short stroke whose release comes too soon for an idle row.
    send_poll(1'b1, 7, 900, 32'd360000);
    send_poll(1'b0, 5, 5, 32'd370000);
    // Panel clock wrap: the delta and the idle test run modulo 2^32.
    send_poll(1'b1, 119, 121, 32'hFFFF_FFF0);
    send_poll(1'b1, 121, 121, 32'h0000_0010);
    send_poll(1'b0, 0, 0, 32'h0001_0000);

    // A band of one single squared radius with idle rows on every change of
    // time: the bounds are inclusive, and equal time gives no idle row.
    settle();
    load_config(32'd10000, 32'd10000, 32'd0, 1'b1);
    send_poll(1'b1, 220, 120, 32'h0002_0000);
    send_poll(1'b1, 221, 120, 32'h0002_0100);
    send_poll(1'b1, 120, 20, 32'h0002_0200);
    send_poll(1'b0, 3, 4, 32'h0002_0300);
    send_poll(1'b0, 3, 4, 32'h0002_0300);
    send_poll(1'b0, 3, 4, 32'h0002_0301);
    clock_us = 32'h0002_0301;

    // Random phases, each under its own register setting: a band covering
    // everything with idle rows never due, an inverted band with idle rows
    // always due, a realistic setting, the reset values, and full range.
    settle();
    load_config(32'd0, 32'd2097152, 32'hFFFF_FFFF, 1'b0);
    run_polls(100);
    settle();
    load_config(32'd2097152, 32'd0, 32'd0, 1'b1);
    run_polls(100);
    settle();
    load_config($urandom_range(0, 20000), $urandom_range(5000, 40000),
                $urandom_range(1000, 200000), 1'b0);
    run_polls(100);
    settle();
    load_config(32'(BAND_INNER_RESET), 32'(BAND_OUTER_RESET), IDLE_INTERVAL_RESET, 1'b1);
    run_polls(100);
    settle();
    load_config($urandom_range(0, 2097152), $urandom_range(0, 2097152), $urandom, 1'b1);
    run_polls(100);
    settle();

    if (fail_count == 0 && rows_waiting == 0) begin
      $display("touch_polar_sample_tagger: match");
    end else begin
      $display("touch_polar_sample_tagger: mismatch");
    end
    $finish;
  end

endmodule
